[hw/rtl/aden_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package aden_pkg;

  localparam int MAX_FIELDS_DEF  = 16;
  localparam int REC_BYTES_DEF   = 136;

  localparam int VAL_W   = 64;
  localparam int EPOCH_W = 32;
  localparam int CNT_W   = 4;
  localparam int FC_W    = 5;
  localparam int PER_W   = 16;
  localparam int TOT_W   = 11;   // total record bits, up to 32 + 16*64
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 64;

  typedef enum logic [1:0] {
    REG_FIELD_COUNT = 2'd0,
    REG_ANCHOR_PER  = 2'd1,
    REG_WIDTH_LO    = 2'd2,
    REG_WIDTH_HI    = 2'd3
  } reg_idx_t;

  localparam logic [FC_W-1:0]    FIELD_COUNT_RST = 5'd1;
  localparam logic [PER_W-1:0]   ANCHOR_PER_RST  = 16'd64;
  localparam logic [EPOCH_W-1:0] CLAMP_POS       = 32'h7FFF_FFFF;
  localparam logic [EPOCH_W-1:0] CLAMP_NEG       = 32'h8000_0001;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_LEN = 1'b1;

endpackage
`default_nettype wire

[hw/rtl/aden_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface aden_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [aden_pkg::VAL_W-1:0] sample_value;
  logic [aden_pkg::EPOCH_W-1:0]     epoch;
  logic                             last_value;

  modport source (output valid, sample_value, epoch, last_value, input ready);
  modport sink   (input valid, sample_value, epoch, last_value, output ready);
endinterface
`default_nettype wire

[hw/rtl/aden_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface aden_out_if;
  logic                         valid;
  logic                         ready;
  logic [aden_pkg::VAL_W-1:0]   out_word;
  logic [aden_pkg::CNT_W-1:0]   byte_count;
  logic                         is_anchor;
  logic                         end_of_record;
  logic                         status;

  modport source (output valid, out_word, byte_count, is_anchor, end_of_record, status,
                  input ready);
  modport sink   (input valid, out_word, byte_count, is_anchor, end_of_record, status,
                  output ready);
endinterface
`default_nettype wire

[hw/rtl/aden_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module aden_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[hw/rtl/anchor_delta_record_encoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// Anchor/delta record encoder. Values of a record arrive one per input transaction,
// the epoch is taken from the first one; the transaction with last_value set closes
// the record. Collection takes one value per cycle while idle (values land in the
// pending RAM). Encoding starts with a setup step, then walks the fields through the
// pending and last-value RAMs, one field at a time: an anchor field steps through read,
// mask and pack; a delta record first encodes the epoch varint (varint, pack), then a
// delta field steps through read and diff when unchanged and through read, diff, clamp,
// varint and pack when changed; a final step closes the record. Bytes are packed into
// 64-bit words in the record RAM; the drain then issues one result transaction per word
// (RAM read, output register), held while the output is stalled. A wrong record length
// yields a single error result with status set and leaves the encoder state untouched.
// The output register lets a new record start collecting while the last result waits.
module anchor_delta_record_encoder #(
  parameter int MAX_FIELDS          = aden_pkg::MAX_FIELDS_DEF,
  parameter int RECORD_BUFFER_BYTES = aden_pkg::REC_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  aden_in_if.sink                          in_ch,
  aden_out_if.source                       out_ch,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [aden_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [aden_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [aden_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                             cfg_pready
);

  localparam int FA_W    = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int RWORDS  = RECORD_BUFFER_BYTES / 8;
  localparam int RA_W    = $clog2(RWORDS);
  localparam int VW      = aden_pkg::VAL_W;
  localparam int EW      = aden_pkg::EPOCH_W;
  localparam int FCW     = aden_pkg::FC_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_RD, ST_CALC, ST_CLAMP, ST_VAR, ST_PACK, ST_FIN, ST_DRD, ST_DOUT
  } state_t;

  // ---------------- configuration registers ----------------
  logic [FCW-1:0]               field_count_r;
  logic [aden_pkg::PER_W-1:0]   anchor_per_r;
  logic [VW-1:0]                width_lo_r, width_hi_r;
  logic                         cfg_wr;
  aden_pkg::reg_idx_t           cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = aden_pkg::reg_idx_t'(cfg_paddr[4:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_idx)
      aden_pkg::REG_FIELD_COUNT: cfg_prdata = VW'(field_count_r);
      aden_pkg::REG_ANCHOR_PER:  cfg_prdata = VW'(anchor_per_r);
      aden_pkg::REG_WIDTH_LO:    cfg_prdata = width_lo_r;
      aden_pkg::REG_WIDTH_HI:    cfg_prdata = width_hi_r;
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_count_r <= aden_pkg::FIELD_COUNT_RST;
      anchor_per_r  <= aden_pkg::ANCHOR_PER_RST;
      width_lo_r    <= '0;
      width_hi_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        aden_pkg::REG_FIELD_COUNT: field_count_r <= cfg_pwdata[FCW-1:0];
        aden_pkg::REG_ANCHOR_PER:  anchor_per_r  <= cfg_pwdata[aden_pkg::PER_W-1:0];
        aden_pkg::REG_WIDTH_LO:    width_lo_r    <= cfg_pwdata;
        aden_pkg::REG_WIDTH_HI:    width_hi_r    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // ---------------- state ----------------
  state_t                 state_r;
  logic [FCW-1:0]         fi_r;            // collection index, saturates at 31
  logic [FCW-1:0]         fld_r;           // field being encoded
  logic [EW-1:0]          rec_epoch_r, prev_epoch_r;
  logic                   init_r;
  logic [aden_pkg::PER_W-1:0] rsa_r;       // records since anchor
  logic [MAX_FIELDS-1:0]  valid_r;
  logic [MAX_FIELDS-1:0]  mask_r;
  logic                   anchor_r, ep_step_r;
  logic [127:0]           acc_r;           // bit accumulator
  logic [5:0]             acc_cnt_r;
  logic [aden_pkg::TOT_W-1:0] tot_r;
  logic [RA_W:0]          wptr_r, k_r;
  logic [7:0]             len_bytes_r;
  logic signed [VW:0]     d_r;
  logic [VW-1:0]          raw_r, val_r;
  logic                   prev_r, nan_r;
  logic [EW-1:0]          e_r;
  logic [6:0]             len_r;

  logic                   out_valid_r, out_anchor_r, out_eor_r, out_status_r;
  logic [VW-1:0]          out_word_r;
  logic [aden_pkg::CNT_W-1:0] out_cnt_r;

  // ---------------- memories ----------------
  logic            pend_we, last_we, rec_we;
  logic [VW-1:0]   pend_rdata, last_rdata, rec_rdata, last_wdata, rec_wdata;

  aden_ram #(.WIDTH(VW), .DEPTH(MAX_FIELDS)) u_pend (
    .clk, .wr_en(pend_we), .wr_addr(fi_r[FA_W-1:0]), .wr_data(in_ch.sample_value),
    .rd_addr(fld_r[FA_W-1:0]), .rd_data(pend_rdata));

  aden_ram #(.WIDTH(VW), .DEPTH(MAX_FIELDS)) u_last (
    .clk, .wr_en(last_we), .wr_addr(fld_r[FA_W-1:0]), .wr_data(last_wdata),
    .rd_addr(fld_r[FA_W-1:0]), .rd_data(last_rdata));

  aden_ram #(.WIDTH(VW), .DEPTH(RWORDS)) u_rec (
    .clk, .wr_en(rec_we), .wr_addr(wptr_r[RA_W-1:0]), .wr_data(rec_wdata),
    .rd_addr(k_r[RA_W-1:0]), .rd_data(rec_rdata));

  // ---------------- input handshake ----------------
  logic           in_acc, out_free, len_bad, last_field, out_load;
  logic [FCW-1:0] count;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && (!in_ch.last_value || out_free);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign count       = (fi_r == 5'd31) ? fi_r : fi_r + 5'd1;
  assign len_bad     = (count != field_count_r) || (32'(field_count_r) > MAX_FIELDS);
  assign pend_we     = in_acc && (32'(fi_r) < MAX_FIELDS);
  assign last_field  = (fld_r + 5'd1) == field_count_r;
  // output register gets a new transaction this cycle
  assign out_load    = ((state_r == ST_IDLE) && in_acc && in_ch.last_value && len_bad) ||
                       ((state_r == ST_DOUT) && out_free);

  // ---------------- per-field datapath ----------------
  logic [7:0]    wbyte;
  logic [6:0]    w;
  logic [VW-1:0] wmask;
  logic          nan, prev, is_anchor_now;

  always_comb begin
    wbyte = fld_r[3] ? width_hi_r[8*fld_r[2:0] +: 8] : width_lo_r[8*fld_r[2:0] +: 8];
    if (wbyte == 8'd0)      w = 7'd1;
    else if (wbyte > 8'd64) w = 7'd64;
    else                    w = wbyte[6:0];
    wmask = (w == 7'd64) ? '1 : ((VW'(1) << w[5:0]) - VW'(1));
  end

  assign nan  = (pend_rdata & wmask) == wmask;
  assign prev = valid_r[fld_r[FA_W-1:0]];
  assign is_anchor_now = !init_r || (rsa_r == '0) || (rsa_r >= anchor_per_r);

  // clamp to +-(2^31-1); identical for delta and absolute values
  logic [EW-1:0] e_cl;
  always_comb begin
    if (d_r > 65'sd2147483647)        e_cl = aden_pkg::CLAMP_POS;
    else if (d_r < -65'sd2147483647)  e_cl = aden_pkg::CLAMP_NEG;
    else                              e_cl = d_r[EW-1:0];
  end

  // zigzag + varint
  logic [EW-1:0] zz;
  logic [2:0]    nb;
  logic [39:0]   vint;
  always_comb begin
    zz = {e_r[30:0], 1'b0} ^ {EW{e_r[31]}};
    if (zz[31:7] == '0)       nb = 3'd1;
    else if (zz[31:14] == '0) nb = 3'd2;
    else if (zz[31:21] == '0) nb = 3'd3;
    else if (zz[31:28] == '0) nb = 3'd4;
    else                      nb = 3'd5;
    vint = {4'd0, zz[31:28], nb > 3'd4, zz[27:21], nb > 3'd3, zz[20:14],
            nb > 3'd2, zz[13:7], nb > 3'd1, zz[6:0]};
  end

  // bit packer
  logic [127:0] acc_ins;
  logic [6:0]   ncnt;
  assign acc_ins = acc_r | ({64'd0, val_r} << acc_cnt_r);
  assign ncnt    = {1'b0, acc_cnt_r} + len_r;

  always_comb begin
    last_we    = 1'b0;
    last_wdata = pend_rdata;
    if (state_r == ST_CALC && anchor_r) begin
      last_we = 1'b1;
    end else if (state_r == ST_CLAMP) begin
      last_we    = 1'b1;
      last_wdata = prev_r ? raw_r : {{32{e_cl[31]}}, e_cl};
    end
    rec_we    = ((state_r == ST_PACK) && ncnt[6]) || ((state_r == ST_FIN) && (acc_cnt_r != '0));
    rec_wdata = (state_r == ST_PACK) ? acc_ins[63:0] : acc_r[63:0];
  end

  // drain
  logic [8:0] rem;
  assign rem = {1'b0, len_bytes_r} - {k_r, 3'b000};

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fi_r         <= '0;
      fld_r        <= '0;
      init_r       <= 1'b0;
      rsa_r        <= '0;
      prev_epoch_r <= '0;
      rec_epoch_r  <= '0;
      valid_r      <= '0;
      mask_r       <= '0;
      out_valid_r  <= 1'b0;
      anchor_r     <= 1'b0;
      ep_step_r    <= 1'b0;
      acc_cnt_r    <= '0;
      tot_r        <= '0;
      wptr_r       <= '0;
      k_r          <= '0;
      len_bytes_r  <= '0;
    end else begin
      if (out_ch.ready && !out_load) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (fi_r == '0) rec_epoch_r <= in_ch.epoch;
            if (!in_ch.last_value) begin
              fi_r <= count;
            end else begin
              fi_r <= '0;
              if (len_bad) begin
                out_valid_r  <= 1'b1;
                out_word_r   <= '0;
                out_cnt_r    <= '0;
                out_anchor_r <= 1'b0;
                out_eor_r    <= 1'b1;
                out_status_r <= aden_pkg::STATUS_BAD_LEN;
              end else begin
                state_r <= ST_START;
              end
            end
          end
        end
        ST_START: begin
          anchor_r <= is_anchor_now;
          mask_r   <= '0;
          fld_r    <= '0;
          wptr_r   <= '0;
          acc_r    <= is_anchor_now ? {96'd0, rec_epoch_r} : '0;
          if (is_anchor_now) begin
            acc_cnt_r     <= 6'd32;
            tot_r         <= 11'd32;
            state_r       <= ST_RD;
          end else begin
            acc_cnt_r <= (field_count_r > 5'd8) ? 6'd16 : 6'd8;
            tot_r     <= (field_count_r > 5'd8) ? 11'd16 : 11'd8;
            e_r       <= rec_epoch_r - prev_epoch_r;
            ep_step_r <= 1'b1;
            state_r   <= ST_VAR;
          end
        end
        ST_RD: state_r <= ST_CALC;
        ST_CALC: begin
          if (anchor_r) begin
            val_r   <= pend_rdata & wmask;
            len_r   <= w;
            valid_r[fld_r[FA_W-1:0]] <= !nan;
            state_r <= ST_PACK;
          end else if ((nan && !prev) || (!nan && prev && pend_rdata == last_rdata)) begin
            if (last_field) begin
              state_r <= ST_FIN;
            end else begin
              fld_r   <= fld_r + 5'd1;
              state_r <= ST_RD;
            end
          end else begin
            raw_r   <= pend_rdata;
            prev_r  <= prev;
            nan_r   <= nan;
            d_r     <= prev ? ({pend_rdata[VW-1], pend_rdata} - {last_rdata[VW-1], last_rdata})
                            : {pend_rdata[VW-1], pend_rdata};
            state_r <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          e_r     <= e_cl;
          valid_r[fld_r[FA_W-1:0]] <= !nan_r;
          mask_r[fld_r[FA_W-1:0]]  <= 1'b1;
          state_r <= ST_VAR;
        end
        ST_VAR: begin
          val_r   <= VW'(vint);
          len_r   <= {1'b0, nb, 3'b000};
          state_r <= ST_PACK;
        end
        ST_PACK: begin
          tot_r <= tot_r + aden_pkg::TOT_W'(len_r);
          if (ncnt[6]) begin
            acc_r     <= {64'd0, acc_ins[127:64]};
            wptr_r    <= wptr_r + 1'b1;
          end else begin
            acc_r     <= acc_ins;
          end
          acc_cnt_r <= ncnt[5:0];
          if (ep_step_r) begin
            ep_step_r <= 1'b0;
            state_r   <= ST_RD;
          end else if (last_field) begin
            state_r <= ST_FIN;
          end else begin
            fld_r   <= fld_r + 5'd1;
            state_r <= ST_RD;
          end
        end
        ST_FIN: begin
          len_bytes_r  <= 8'((tot_r + 11'd7) >> 3);
          init_r       <= 1'b1;
          rsa_r        <= anchor_r ? 16'd1 : rsa_r + 16'd1;
          prev_epoch_r <= rec_epoch_r;
          k_r          <= '0;
          state_r      <= ST_DRD;
        end
        ST_DRD: state_r <= ST_DOUT;
        ST_DOUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_word_r   <= rec_rdata |
                            ((k_r == '0 && !anchor_r) ? VW'(mask_r) : VW'(0));
            out_cnt_r    <= (rem > 9'd8) ? 4'd8 : rem[3:0];
            out_anchor_r <= anchor_r;
            out_eor_r    <= (rem <= 9'd8);
            out_status_r <= aden_pkg::STATUS_OK;
            if (rem <= 9'd8) begin
              state_r <= ST_IDLE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= ST_DRD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_word      = out_word_r;
  assign out_ch.byte_count    = out_cnt_r;
  assign out_ch.is_anchor     = out_anchor_r;
  assign out_ch.end_of_record = out_eor_r;
  assign out_ch.status        = out_status_r;

  // ---------------- assertions ----------------
  a_wptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wptr_r) <= RWORDS) else $error("record word pointer past buffer");

  a_good_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == aden_pkg::STATUS_OK) |->
      (out_cnt_r != '0 && out_cnt_r <= 4'd8)) else $error("bad byte count");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == aden_pkg::STATUS_BAD_LEN) |->
      (out_cnt_r == '0 && out_eor_r && !out_anchor_r)) else $error("bad error result");

  a_mask_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DOUT) |-> ((32'(mask_r) >> field_count_r) == 0))
    else $error("change mask beyond field count");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_word_r)))
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;

  // One result transaction as the encoder presents it.
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  cnt;
    logic        anchor;
    logic        eor;
    logic        status;
  } rec_word_t;

  // Directed stimulus row. Rows with typed set carry their expected result
  // (only used on rows that close a record).
  typedef struct {
    logic [63:0] value;
    logic [31:0] epoch;
    bit          last;
    bit          typed;
    rec_word_t   want;
  } stim_row_t;

  localparam int IDLE_LIMIT = 20000;   // cycles without any transaction
  localparam int SETTLE     = 60;      // encode + drain latency margin

  logic clk;
  logic rst_n;

  aden_in_if  in_ch();
  aden_out_if out_ch();

  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [aden_pkg::CFG_AW-1:0] cfg_paddr;
  logic [aden_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [aden_pkg::CFG_DW-1:0] cfg_prdata;
  logic                        cfg_pready;

  anchor_delta_record_encoder DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // ---------------------------------------------------------------------------
  // Encoder shadow state: configuration, history and the record being collected
  // ---------------------------------------------------------------------------
  logic [4:0]  fc_reg;
  logic [15:0] period_reg;
  logic [63:0] wlo_reg, whi_reg;

  bit          enc_init;
  logic [15:0] since_anchor;
  logic [31:0] prev_epoch;
  logic [63:0] hist_val [16];
  bit          hist_ok  [16];
  logic [63:0] pend_val [16];
  int          coll_idx;
  logic [31:0] coll_epoch;

  logic [7:0]  rec_bytes [$];   // bytes of the record being encoded
  rec_word_t   words_due [$];   // results still owed by the encoder

  int  errors;
  bit  no_idle;                 // burst stretch: neither side idles
  int  idle_cycles;

  // ---------------------------------------------------------------------------
  // Clock, reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    errors++;
  endtask

  // Field width as the encoder sees it: 0 acts as 1, above 64 acts as 64.
  function automatic int field_width(input int i);
    logic [63:0] w64;
    int w;
    w64 = (i < 8) ? wlo_reg : whi_reg;
    w = int'(w64[8*(i%8) +: 8]);
    if (w == 0) w = 1;
    if (w > 64) w = 64;
    return w;
  endfunction

  function automatic logic [63:0] width_mask(input int w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  task automatic put_zigzag(input logic [31:0] e);
    logic [31:0] u;
    u = {e[30:0], 1'b0} ^ {32{e[31]}};
    while (u >= 32'h80) begin
      rec_bytes.push_back({1'b1, u[6:0]});
      u = u >> 7;
    end
    rec_bytes.push_back(u[7:0]);
  endtask

  task automatic build_anchor(input int n);
    logic [1087:0] bits;
    int off, w, nbytes;
    bits = '0;
    bits[31:0] = coll_epoch;
    off = 32;
    for (int i = 0; i < n; i++) begin
      w = field_width(i);
      for (int k = 0; k < w; k++) bits[off + k] = pend_val[i][k];
      off += w;
      hist_val[i] = pend_val[i];
      hist_ok[i]  = (pend_val[i] & width_mask(w)) != width_mask(w);
    end
    nbytes = (off + 7) / 8;
    if (nbytes < 4) nbytes = 4;
    for (int b = 0; b < nbytes; b++) rec_bytes.push_back(bits[8*b +: 8]);
    since_anchor = 16'd1;
    enc_init = 1'b1;
    prev_epoch = coll_epoch;
  endtask

  task automatic build_delta(input int n);
    logic [15:0] mask;
    logic [63:0] raw, mag;
    logic [31:0] e;
    int w;
    bit nan, had;
    mask = '0;
    rec_bytes.push_back(8'h00);
    if (n > 8) rec_bytes.push_back(8'h00);
    put_zigzag(coll_epoch - prev_epoch);
    for (int i = 0; i < n; i++) begin
      raw = pend_val[i];
      w   = field_width(i);
      nan = (raw & width_mask(w)) == width_mask(w);
      had = hist_ok[i];
      if (nan && !had) continue;
      if (!nan && had && raw == hist_val[i]) continue;
      mask[i] = 1'b1;
      if (had) begin
        if ($signed(raw) >= $signed(hist_val[i])) begin
          mag = raw - hist_val[i];
          if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
          e = mag[31:0];
        end else begin
          mag = hist_val[i] - raw;
          if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
          e = 32'd0 - mag[31:0];
        end
      end else begin
        // absolute value, clamped; the clamped value becomes the history
        if ($signed(raw) > $signed(64'h7FFF_FFFF)) raw = 64'h7FFF_FFFF;
        else if ($signed(raw) < $signed({{32{1'b1}}, aden_pkg::CLAMP_NEG}))
          raw = {{32{1'b1}}, aden_pkg::CLAMP_NEG};
        e = raw[31:0];
      end
      put_zigzag(e);
      hist_val[i] = raw;
      hist_ok[i]  = !nan;
    end
    rec_bytes[0] = mask[7:0];
    if (n > 8) rec_bytes[1] = mask[15:8];
    since_anchor = since_anchor + 16'd1;
    prev_epoch = coll_epoch;
  endtask

  // Advance the shadow encoder by one accepted input transaction; when keep is
  // set, the results it owes are queued for checking.
  task automatic predict_sample(input logic [63:0] v, input logic [31:0] ep,
                                input bit lst, input bit keep);
    int cnt, nres, nb;
    bit anchor;
    rec_word_t r;
    if (coll_idx == 0) coll_epoch = ep;
    if (coll_idx < 16) pend_val[coll_idx] = v;
    cnt = (coll_idx < 31) ? coll_idx + 1 : 31;
    if (!lst) begin
      coll_idx = cnt;
      return;
    end
    coll_idx = 0;
    if (cnt != int'(fc_reg) || fc_reg > 5'd16) begin
      r = '{word: '0, cnt: '0, anchor: 1'b0, eor: 1'b1, status: aden_pkg::STATUS_BAD_LEN};
      if (keep) words_due.push_back(r);
      return;
    end
    anchor = !enc_init || since_anchor == 16'd0 || since_anchor >= period_reg;
    rec_bytes.delete();
    if (anchor) build_anchor(cnt);
    else build_delta(cnt);
    nres = (rec_bytes.size() + 7) / 8;
    for (int k = 0; k < nres; k++) begin
      nb = rec_bytes.size() - 8*k;
      if (nb > 8) nb = 8;
      r = '{word: '0, cnt: nb[3:0], anchor: anchor, eor: (k == nres - 1),
            status: aden_pkg::STATUS_OK};
      for (int j = 0; j < nb; j++) r.word[8*j +: 8] = rec_bytes[8*k + j];
      if (keep) words_due.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_sample(input logic [63:0] v, input logic [31:0] ep, input bit lst,
                             input bit typed, input rec_word_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample_value <= v;
    in_ch.epoch        <= ep;
    in_ch.last_value   <= lst;
    do @(posedge clk); while (!in_ch.ready);
    predict_sample(v, ep, lst, !typed);
    if (typed && lst) words_due.push_back(want);
  endtask

  // Value for field i: repeats, NaN, small steps, full-range and extreme values.
  function automatic logic [63:0] pick_value(input int i);
    int r, w;
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    if (i >= 16) return rnd;
    w = field_width(i);
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2: return hist_val[i];
      3:       return rnd | width_mask(w);
      4:       return hist_val[i] + {{32{rnd[63]}}, rnd[31:0]} % 64'd200 - 64'd100;
      5:       return rnd;
      6: begin
        case ($urandom_range(0, 5))
          0: return 64'h7FFF_FFFF_FFFF_FFFF;
          1: return 64'h8000_0000_0000_0000;
          2: return 64'h0;
          3: return '1;
          4: return 64'h0000_0000_8000_0000;
          default: return 64'hFFFF_FFFF_8000_0000;
        endcase
      end
      default: return rnd & width_mask(w);
    endcase
  endfunction

  task automatic send_record(input int len);
    logic [31:0] ep;
    rec_word_t none;
    none = '0;
    case ($urandom_range(0, 9))
      0, 1:    ep = $urandom;
      2:       ep = prev_epoch - $urandom_range(0, 50);
      default: ep = prev_epoch + $urandom_range(0, 100);
    endcase
    // later items carry junk epochs; only the first one counts
    for (int k = 0; k < len; k++)
      send_sample(pick_value(k), (k == 0) ? ep : $urandom, k == len - 1, 1'b0, none);
  endtask

  // Mostly well-formed records, some of the wrong length.
  function automatic int pick_len();
    if ($urandom_range(0, 99) < 85 && fc_reg >= 5'd1 && fc_reg <= 5'd16) return int'(fc_reg);
    return $urandom_range(1, 18);
  endfunction

  task automatic wait_drained();
    while (words_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  task automatic cfg_write(input aden_pkg::reg_idx_t idx, input logic [63:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= aden_pkg::CFG_AW'(idx) << 3;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      aden_pkg::REG_FIELD_COUNT: fc_reg     = data[4:0];
      aden_pkg::REG_ANCHOR_PER:  period_reg = data[15:0];
      aden_pkg::REG_WIDTH_LO:    wlo_reg    = data;
      aden_pkg::REG_WIDTH_HI:    whi_reg    = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [4:0] fc, input logic [15:0] per,
                            input logic [63:0] lo, input logic [63:0] hi);
    cfg_write(aden_pkg::REG_FIELD_COUNT, 64'(fc));
    cfg_write(aden_pkg::REG_ANCHOR_PER,  64'(per));
    cfg_write(aden_pkg::REG_WIDTH_LO,    lo);
    cfg_write(aden_pkg::REG_WIDTH_HI,    hi);
  endtask

  function automatic logic [63:0] random_widths();
    logic [63:0] w;
    for (int b = 0; b < 8; b++) w[8*b +: 8] = 8'($urandom_range(0, 70));
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and checking
  // ---------------------------------------------------------------------------
  int stall_left;
  always @(posedge clk) begin
    if (no_idle) begin
      out_ch.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3: stall_left <= $urandom_range(1, 3);
        4:          stall_left <= $urandom_range(10, 40);
        default:    stall_left <= 0;
      endcase
    end
  end

  always @(posedge clk) begin
    rec_word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (words_due.size() == 0) begin
        report($sformatf("unexpected result word %h", out_ch.out_word));
      end else begin
        w = words_due.pop_front();
        if (out_ch.out_word !== w.word)
          report($sformatf("out_word %h, want %h", out_ch.out_word, w.word));
        if (out_ch.byte_count !== w.cnt)
          report($sformatf("byte_count %0d, want %0d", out_ch.byte_count, w.cnt));
        if (out_ch.is_anchor !== w.anchor)
          report($sformatf("is_anchor %b, want %b", out_ch.is_anchor, w.anchor));
        if (out_ch.end_of_record !== w.eor)
          report($sformatf("end_of_record %b, want %b", out_ch.end_of_record, w.eor));
        if (out_ch.status !== w.status)
          report($sformatf("status %b, want %b", out_ch.status, w.status));
      end
    end
  end

  // Watchdog: any transaction on either channel or the config port resets it.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[anchor_delta_record_encoder] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  stim_row_t dir_rows [$];

  function automatic void add_row(input logic [63:0] v, input logic [31:0] ep,
                                  input bit lst, input bit typed, input rec_word_t want);
    stim_row_t r;
    r.value = v; r.epoch = ep; r.last = lst; r.typed = typed; r.want = want;
    dir_rows.push_back(r);
  endfunction

  initial begin
    rec_word_t none, bad_len;
    none    = '0;
    bad_len = '{word: '0, cnt: '0, anchor: 1'b0, eor: 1'b1,
                status: aden_pkg::STATUS_BAD_LEN};

    errors = 0; no_idle = 0; idle_cycles = 0; stall_left = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.sample_value = '0; in_ch.epoch = '0; in_ch.last_value = 1'b0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0; cfg_paddr = '0; cfg_pwdata = '0;

    // reset values of the shadow encoder
    fc_reg = aden_pkg::FIELD_COUNT_RST; period_reg = aden_pkg::ANCHOR_PER_RST;
    wlo_reg = '0; whi_reg = '0;
    enc_init = 0; since_anchor = '0; prev_epoch = '0; coll_idx = 0; coll_epoch = '0;
    for (int i = 0; i < 16; i++) begin
      hist_val[i] = '0; hist_ok[i] = 0; pend_val[i] = '0;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset configuration: one field, one bit wide.
    // First record is an anchor: epoch LE then the single value bit.
    add_row(64'd1, 32'h1234_5678, 1,
            1, '{word: 64'h0000_0001_1234_5678, cnt: 4'd5, anchor: 1, eor: 1,
                 status: aden_pkg::STATUS_OK});
    // wrong length; epoch of the second item must be ignored
    add_row(64'd0, 32'hFFFF_FFFF, 0, 0, none);
    add_row(64'd5, 32'h0000_0000, 1, 1, bad_len);
    add_row(64'd0,                    32'h1234_5679, 1, 0, none);
    add_row(64'h8000_0000_0000_0000, 32'h1234_567A, 1, 0, none);
    add_row(64'h7FFF_FFFF_FFFF_FFFF, 32'h0000_0000, 1, 0, none);
    add_row('1,                       32'hFFFF_FFFF, 1, 0, none);
    add_row(64'd0,                    32'h8000_0000, 1, 0, none);
    add_row(64'd2,                    32'h8000_0000, 1, 0, none);
    add_row(64'd3, 32'd7, 0, 0, none);
    add_row(64'd4, 32'd8, 0, 0, none);
    add_row(64'd5, 32'd9, 1, 1, bad_len);
    add_row(64'd1, 32'h7FFF_FFFF, 1, 0, none);
    foreach (dir_rows[i])
      send_sample(dir_rows[i].value, dir_rows[i].epoch, dir_rows[i].last,
                  dir_rows[i].typed, dir_rows[i].want);
    in_ch.valid <= 1'b0;
    wait_drained();

    // Sixteen 64-bit fields, every record an anchor: the longest record.
    set_config(5'd16, 16'd0, 64'h4040_4040_4040_4040, 64'h4040_4040_4040_4040);
    send_record(16);
    in_ch.valid <= 1'b0;
    wait_drained();

    // Odd width bytes (0 and above 64), longest period, no idling anywhere.
    no_idle = 1;
    set_config(5'd16, 16'hFFFF, 64'hFF00_41FF_0000_FF00, 64'h00FF_0080_0041_00FF);
    for (int r = 0; r < 2; r++) send_record(16);
    in_ch.valid <= 1'b0;
    wait_drained();
    no_idle = 0;

    // field_count of zero: every record fails.
    set_config(5'd0, 16'd1, 64'h0101_0101_0101_0101, 64'h0808_0808_0808_0808);
    send_record(1);
    send_record(2);
    in_ch.valid <= 1'b0;
    wait_drained();

    // field_count above the field limit, with an over-long record that
    // saturates the item count.
    set_config(5'd31, 16'd1, 64'h0101_0101_0101_0101, 64'h0808_0808_0808_0808);
    send_record(32);
    in_ch.valid <= 1'b0;
    wait_drained();

    // Random phases: random sizes, periods and widths.
    for (int ph = 0; ph < 3; ph++) begin
      set_config(5'($urandom_range(1, 3)),
                 16'((ph == 1) ? 1 : $urandom_range(2, 6)),
                 random_widths(), random_widths());
      no_idle = (ph == 2);
      for (int r = 0; r < 3; r++) begin
        send_record(pick_len());
        // hold the sender until the encoder has caught up
        if (r == 1 && ph != 1) begin
          in_ch.valid <= 1'b0;
          while (words_due.size() != 0) @(posedge clk);
        end
      end
      in_ch.valid <= 1'b0;
      wait_drained();
    end
    no_idle = 0;

    wait_drained();
    if (errors == 0)
      $display("[anchor_delta_record_encoder] OK");
    else
      $display("[anchor_delta_record_encoder] ERROR");
    $finish;
  end

endmodule

[anchor_delta_record_encoder.f]
hw/rtl/aden_pkg.sv
hw/rtl/aden_in_if.sv
hw/rtl/aden_out_if.sv
hw/rtl/aden_ram.sv
hw/rtl/anchor_delta_record_encoder.sv
tb/tb.sv
